// ===== sv/otq_pkg.sv =====
`default_nettype none

package otq_pkg;

    localparam int TIME_W      = 48;
    localparam int ID_W        = 32;
    localparam int TAG_W       = 16;
    localparam int DELAY_W     = 32;
    localparam int KIND_W      = 2;
    localparam int CMD_W       = 1;

    localparam int DEPTH_DEF   = 16;
    localparam int MAX_RESULTS = 16;
    localparam int FIRE_CNT_W  = $clog2(MAX_RESULTS + 1);

    localparam logic [CMD_W-1:0] CMD_ADD  = 1'b0;
    localparam logic [CMD_W-1:0] CMD_TICK = 1'b1;

    localparam logic [KIND_W-1:0] KIND_ACCEPT = 2'd0;
    localparam logic [KIND_W-1:0] KIND_REJECT = 2'd1;
    localparam logic [KIND_W-1:0] KIND_FIRED  = 2'd2;

endpackage

`default_nettype wire

// ===== sv/otq_ifs.sv =====
`default_nettype none

interface otq_req_if;
    import otq_pkg::*;

    logic               valid;
    logic               ready;
    logic [CMD_W-1:0]   cmd;
    logic [DELAY_W-1:0] delay_ms;
    logic [TAG_W-1:0]   tag;

    modport source (output valid, cmd, delay_ms, tag, input ready);
    modport sink   (input valid, cmd, delay_ms, tag, output ready);
endinterface

interface otq_rsp_if;
    import otq_pkg::*;

    logic              valid;
    logic              ready;
    logic [KIND_W-1:0] kind;
    logic [ID_W-1:0]   timer_id;
    logic [TAG_W-1:0]  fired_tag;
    logic [TIME_W-1:0] deadline;
    logic              last;

    modport source (output valid, kind, timer_id, fired_tag, deadline, last, input ready);
    modport sink   (input valid, kind, timer_id, fired_tag, deadline, last, output ready);
endinterface

`default_nettype wire

// ===== sv/ordered_timer_queue_core.sv =====
// Add: taken in ST_IDLE; ST_ADD loads the answer into the output register when it is free.
// Tick: every fired timer costs one full pass over the table through the single registered
// memory read port and one key comparator; passes repeat until one finds no due timer or
// MAX_RESULTS timers have fired. One word at a time.
// Reset (rst_n, async low): time and id zero, all slots free; slot contents need no clearing.
`default_nettype none

module ordered_timer_queue_core #(
    parameter int DEPTH = otq_pkg::DEPTH_DEF
) (
    input  wire        clk,
    input  wire        rst_n,
    otq_req_if.sink    req,
    otq_rsp_if.source  rsp
);
    import otq_pkg::*;

    localparam int IDX_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNT_W = $clog2(DEPTH + 1);
    localparam logic [CNT_W-1:0] SCAN_END = CNT_W'(DEPTH);
    localparam logic [FIRE_CNT_W-1:0] FIRE_MAX = FIRE_CNT_W'(MAX_RESULTS);

    localparam logic [1:0] ST_IDLE  = 2'd0;
    localparam logic [1:0] ST_ADD   = 2'd1;
    localparam logic [1:0] ST_SCAN  = 2'd2;
    localparam logic [1:0] ST_FLUSH = 2'd3;

    // slot storage
    logic [TIME_W-1:0] dl_mem  [DEPTH];
    logic [ID_W-1:0]   id_mem  [DEPTH];
    logic [TAG_W-1:0]  tag_mem [DEPTH];

    logic [1:0]            state_reg, state_next;
    logic [TIME_W-1:0]     cur_time_reg, cur_time_next;
    logic [ID_W-1:0]       next_id_reg, next_id_next;
    logic [DEPTH-1:0]      valid_reg, valid_next;
    logic [DELAY_W-1:0]    dly_reg, dly_next;
    logic [TAG_W-1:0]      tag_reg, tag_next;

    logic [CNT_W-1:0]      scan_cnt_reg, scan_cnt_next;
    logic                  rd_pend_reg, rd_pend_next;
    logic [IDX_W-1:0]      rd_idx_reg, rd_idx_next;
    logic                  rd_vld_reg;
    logic [TIME_W-1:0]     rd_dl_reg;
    logic [ID_W-1:0]       rd_id_reg;
    logic [TAG_W-1:0]      rd_tag_reg;

    logic                  found_reg, found_next;
    logic [IDX_W-1:0]      best_idx_reg, best_idx_next;
    logic [TIME_W-1:0]     best_dl_reg, best_dl_next;
    logic [ID_W-1:0]       best_id_reg, best_id_next;
    logic [TAG_W-1:0]      best_tag_reg, best_tag_next;

    logic                  held_reg, held_next;
    logic [TIME_W-1:0]     held_dl_reg, held_dl_next;
    logic [ID_W-1:0]       held_id_reg, held_id_next;
    logic [TAG_W-1:0]      held_tag_reg, held_tag_next;
    logic [FIRE_CNT_W-1:0] fire_cnt_reg, fire_cnt_next;

    logic                  out_valid_reg, out_valid_next;
    logic [KIND_W-1:0]     out_kind_reg, out_kind_next;
    logic [ID_W-1:0]       out_id_reg, out_id_next;
    logic [TAG_W-1:0]      out_tag_reg, out_tag_next;
    logic [TIME_W-1:0]     out_dl_reg, out_dl_next;
    logic                  out_last_reg, out_last_next;

    logic [IDX_W-1:0]      rd_addr;
    logic [IDX_W-1:0]      free_idx;
    logic                  free_any;
    logic [TIME_W:0]       dl_sum;
    logic [TIME_W-1:0]     add_dl;
    logic                  out_free;
    logic                  due;
    logic                  better;
    logic                  mem_we;

    assign req.ready     = (state_reg == ST_IDLE);
    assign rsp.valid     = out_valid_reg;
    assign rsp.kind      = out_kind_reg;
    assign rsp.timer_id  = out_id_reg;
    assign rsp.fired_tag = out_tag_reg;
    assign rsp.deadline  = out_dl_reg;
    assign rsp.last      = out_last_reg;

    assign rd_addr  = scan_cnt_reg[IDX_W-1:0];
    assign out_free = !out_valid_reg || rsp.ready;

    // saturate the deadline at the top of the time range
    assign dl_sum = {1'b0, cur_time_reg} + {{(TIME_W + 1 - DELAY_W){1'b0}}, dly_reg};
    assign add_dl = dl_sum[TIME_W] ? {TIME_W{1'b1}} : dl_sum[TIME_W-1:0];

    assign due    = rd_vld_reg && (rd_dl_reg <= cur_time_reg);
    assign better = !found_reg || (rd_dl_reg < best_dl_reg) ||
                    ((rd_dl_reg == best_dl_reg) && (rd_id_reg < best_id_reg));

    // lowest free slot
    always_comb
    begin
        free_idx = '0;
        free_any = 1'b0;
        for (int i = DEPTH - 1; i >= 0; i--)
        begin
            if (!valid_reg[i])
            begin
                free_idx = IDX_W'(i);
                free_any = 1'b1;
            end
        end
    end

    always_comb
    begin
        state_next     = state_reg;
        cur_time_next  = cur_time_reg;
        next_id_next   = next_id_reg;
        valid_next     = valid_reg;
        dly_next       = dly_reg;
        tag_next       = tag_reg;
        scan_cnt_next  = scan_cnt_reg;
        rd_pend_next   = rd_pend_reg;
        rd_idx_next    = rd_idx_reg;
        found_next     = found_reg;
        best_idx_next  = best_idx_reg;
        best_dl_next   = best_dl_reg;
        best_id_next   = best_id_reg;
        best_tag_next  = best_tag_reg;
        held_next      = held_reg;
        held_dl_next   = held_dl_reg;
        held_id_next   = held_id_reg;
        held_tag_next  = held_tag_reg;
        fire_cnt_next  = fire_cnt_reg;
        out_valid_next = out_valid_reg;
        out_kind_next  = out_kind_reg;
        out_id_next    = out_id_reg;
        out_tag_next   = out_tag_reg;
        out_dl_next    = out_dl_reg;
        out_last_next  = out_last_reg;
        mem_we         = 1'b0;

        if (rsp.valid && rsp.ready)
        begin
            out_valid_next = 1'b0;
        end

        unique case (state_reg)
            ST_IDLE:
            begin
                if (req.valid)
                begin
                    if (req.cmd == CMD_ADD)
                    begin
                        dly_next   = req.delay_ms;
                        tag_next   = req.tag;
                        state_next = ST_ADD;
                    end
                    else
                    begin
                        cur_time_next = cur_time_reg + TIME_W'(1);
                        fire_cnt_next = '0;
                        held_next     = 1'b0;
                        scan_cnt_next = '0;
                        rd_pend_next  = 1'b0;
                        found_next    = 1'b0;
                        state_next    = ST_SCAN;
                    end
                end
            end

            ST_ADD:
            begin
                if (out_free)
                begin
                    out_valid_next = 1'b1;
                    out_tag_next   = tag_reg;
                    out_dl_next    = add_dl;
                    out_last_next  = 1'b1;
                    if (free_any)
                    begin
                        mem_we               = 1'b1;
                        valid_next[free_idx] = 1'b1;
                        next_id_next         = next_id_reg + ID_W'(1);
                        out_kind_next        = KIND_ACCEPT;
                        out_id_next          = next_id_reg + ID_W'(1);
                    end
                    else
                    begin
                        out_kind_next = KIND_REJECT;
                        out_id_next   = '0;
                    end
                    state_next = ST_IDLE;
                end
            end

            ST_SCAN:
            begin
                // issue one slot read per cycle, compare the previous one
                if (scan_cnt_reg != SCAN_END)
                begin
                    scan_cnt_next = scan_cnt_reg + CNT_W'(1);
                    rd_pend_next  = 1'b1;
                    rd_idx_next   = rd_addr;
                end
                else
                begin
                    rd_pend_next = 1'b0;
                end

                if (rd_pend_reg && due && better)
                begin
                    found_next    = 1'b1;
                    best_idx_next = rd_idx_reg;
                    best_dl_next  = rd_dl_reg;
                    best_id_next  = rd_id_reg;
                    best_tag_next = rd_tag_reg;
                end

                // pass done: release the held word, park the new winner
                if ((scan_cnt_reg == SCAN_END) && !rd_pend_reg && (!held_reg || out_free))
                begin
                    if (held_reg)
                    begin
                        out_valid_next = 1'b1;
                        out_kind_next  = KIND_FIRED;
                        out_id_next    = held_id_reg;
                        out_tag_next   = held_tag_reg;
                        out_dl_next    = held_dl_reg;
                        out_last_next  = !found_reg;
                    end
                    held_next = 1'b0;
                    if (found_reg)
                    begin
                        held_next                = 1'b1;
                        held_dl_next             = best_dl_reg;
                        held_id_next             = best_id_reg;
                        held_tag_next            = best_tag_reg;
                        valid_next[best_idx_reg] = 1'b0;
                        fire_cnt_next            = fire_cnt_reg + FIRE_CNT_W'(1);
                        if (fire_cnt_reg + FIRE_CNT_W'(1) == FIRE_MAX)
                        begin
                            state_next = ST_FLUSH;
                        end
                        else
                        begin
                            scan_cnt_next = '0;
                            found_next    = 1'b0;
                        end
                    end
                    else
                    begin
                        state_next = ST_IDLE;
                    end
                end
            end

            ST_FLUSH:
            begin
                if (out_free)
                begin
                    out_valid_next = 1'b1;
                    out_kind_next  = KIND_FIRED;
                    out_id_next    = held_id_reg;
                    out_tag_next   = held_tag_reg;
                    out_dl_next    = held_dl_reg;
                    out_last_next  = 1'b1;
                    held_next      = 1'b0;
                    state_next     = ST_IDLE;
                end
            end

            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            cur_time_reg  <= '0;
            next_id_reg   <= '0;
            valid_reg     <= '0;
            scan_cnt_reg  <= '0;
            rd_pend_reg   <= 1'b0;
            found_reg     <= 1'b0;
            held_reg      <= 1'b0;
            fire_cnt_reg  <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            cur_time_reg  <= cur_time_next;
            next_id_reg   <= next_id_next;
            valid_reg     <= valid_next;
            scan_cnt_reg  <= scan_cnt_next;
            rd_pend_reg   <= rd_pend_next;
            found_reg     <= found_next;
            held_reg      <= held_next;
            fire_cnt_reg  <= fire_cnt_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        dly_reg      <= dly_next;
        tag_reg      <= tag_next;
        rd_idx_reg   <= rd_idx_next;
        best_idx_reg <= best_idx_next;
        best_dl_reg  <= best_dl_next;
        best_id_reg  <= best_id_next;
        best_tag_reg <= best_tag_next;
        held_dl_reg  <= held_dl_next;
        held_id_reg  <= held_id_next;
        held_tag_reg <= held_tag_next;
        out_kind_reg <= out_kind_next;
        out_id_reg   <= out_id_next;
        out_tag_reg  <= out_tag_next;
        out_dl_reg   <= out_dl_next;
        out_last_reg <= out_last_next;
    end

    // slot memory: one write port, one registered read port
    always_ff @(posedge clk)
    begin
        if (mem_we)
        begin
            dl_mem[free_idx]  <= add_dl;
            id_mem[free_idx]  <= next_id_reg + ID_W'(1);
            tag_mem[free_idx] <= tag_reg;
        end
        rd_dl_reg  <= dl_mem[rd_addr];
        rd_id_reg  <= id_mem[rd_addr];
        rd_tag_reg <= tag_mem[rd_addr];
        rd_vld_reg <= valid_reg[rd_addr];
    end

    a_tick_advances: assert property (@(posedge clk) disable iff (!rst_n)
        (req.valid && req.ready && (req.cmd == CMD_TICK))
        |=> (cur_time_reg == $past(cur_time_reg) + TIME_W'(1)))
        else $error("tick did not advance time by one");

    a_add_single_word: assert property (@(posedge clk) disable iff (!rst_n)
        (rsp.valid && (rsp.kind != KIND_FIRED)) |-> rsp.last)
        else $error("add answer without last");

    a_fire_bound: assert property (@(posedge clk) disable iff (!rst_n)
        fire_cnt_reg <= FIRE_MAX)
        else $error("too many timers fired on one tick");

    a_held_counted: assert property (@(posedge clk) disable iff (!rst_n)
        held_reg |-> (fire_cnt_reg != '0))
        else $error("held word without a fire count");

endmodule

`default_nettype wire

// ===== dv/testbench.sv =====
module testbench;
    timeunit 1ns;
    timeprecision 1ps;

    import otq_pkg::*;

    localparam int SLOTS         = DEPTH_DEF;
    localparam int RANDOM_WORDS  = 205;
    localparam int CALM_WORDS    = 40;
    localparam int LONG_HOLD     = 300;
    localparam int MAX_PERMANENT = 3;
    localparam int DRAIN_CYCLES  = (MAX_RESULTS + 1) * (SLOTS + 2) + 20;
    localparam int CYCLE_LIMIT   = 500000;
    localparam int DIR_ROWS      = 12;

    typedef struct packed {
        logic [KIND_W-1:0] kind;
        logic [ID_W-1:0]   id;
        logic [TAG_W-1:0]  tag;
        logic [TIME_W-1:0] deadline;
        logic              last;
    } timer_word_t;

    typedef struct packed {
        logic [CMD_W-1:0]   cmd;
        logic [DELAY_W-1:0] delay;
        logic [TAG_W-1:0]   tag;
        int                 reps;
        bit                 typed;
        timer_word_t        want;
    } stim_row_t;

    // Directed sequence: extremes, fire order on equal deadlines, full table, a quiet tick.
    stim_row_t dir_rows [DIR_ROWS] = '{
        '{CMD_ADD,  32'h0000_0000, 16'h0000, 1,  1'b1,
          '{KIND_ACCEPT, 32'd1, 16'h0000, 48'h0000_0000_0000, 1'b1}},
        '{CMD_ADD,  32'hFFFF_FFFF, 16'hFFFF, 1,  1'b1,
          '{KIND_ACCEPT, 32'd2, 16'hFFFF, 48'h0000_FFFF_FFFF, 1'b1}},
        '{CMD_TICK, 32'h0000_0000, 16'h0000, 1,  1'b0, '0},
        '{CMD_ADD,  32'd2,         16'h1234, 1,  1'b0, '0},
        '{CMD_ADD,  32'd1,         16'hA5A5, 1,  1'b0, '0},
        '{CMD_ADD,  32'd2,         16'h5A5A, 1,  1'b0, '0},
        '{CMD_TICK, 32'hDEAD_BEEF, 16'hBEEF, 1,  1'b0, '0},
        '{CMD_TICK, 32'h0000_0000, 16'h0000, 1,  1'b0, '0},
        '{CMD_ADD,  32'd1,         16'h0F00, 15, 1'b0, '0},
        '{CMD_ADD,  32'h8000_0000, 16'h7E81, 1,  1'b1,
          '{KIND_REJECT, 32'd0, 16'h7E81, 48'h0000_8000_0003, 1'b1}},
        '{CMD_TICK, 32'h0000_0000, 16'h0000, 1,  1'b0, '0},
        '{CMD_TICK, 32'h0000_0000, 16'h0000, 1,  1'b0, '0}
    };

    logic clk   = 1'b0;
    logic rst_n = 1'b0;

    otq_req_if req_bus ();
    otq_rsp_if rsp_bus ();

    ordered_timer_queue_core #(
        .DEPTH (SLOTS)
    ) u_top (
        .clk   (clk),
        .rst_n (rst_n),
        .req   (req_bus),
        .rsp   (rsp_bus)
    );

    always #5 clk = ~clk;

    // Timer table mirror
    logic [TIME_W-1:0] now_ms  = '0;
    logic [ID_W-1:0]   last_id = '0;
    bit                slot_busy     [SLOTS];
    logic [TIME_W-1:0] slot_deadline [SLOTS];
    logic [ID_W-1:0]   slot_id       [SLOTS];
    logic [TAG_W-1:0]  slot_tag      [SLOTS];

    timer_word_t due_words [$];
    int          mismatches  = 0;
    int          cycle_count = 0;
    int          permanent   = 0;
    logic        calm        = 1'b0;
    logic        hold_rsp    = 1'b0;

    task automatic report_mismatch(input string what);
        $display("mismatch at %0t: %s", $realtime, what);
        mismatches++;
    endtask

    function automatic void step_timers(input logic [CMD_W-1:0] cmd,
                                        input logic [DELAY_W-1:0] delay,
                                        input logic [TAG_W-1:0] tag,
                                        ref timer_word_t words[$]);
        logic [TIME_W:0]   sum;
        logic [TIME_W-1:0] dl;
        int                slot;
        int                best;
        int                fired;
        bit                held;
        bit                done;
        timer_word_t       w;

        if (cmd == CMD_ADD) begin
            sum = {1'b0, now_ms} + {{(TIME_W + 1 - DELAY_W){1'b0}}, delay};
            dl  = sum[TIME_W] ? {TIME_W{1'b1}} : sum[TIME_W-1:0];
            slot = -1;
            for (int i = 0; i < SLOTS; i++)
                if (!slot_busy[i] && slot < 0)
                    slot = i;
            if (slot < 0) begin
                words.push_back(timer_word_t'{KIND_REJECT, {ID_W{1'b0}}, tag, dl, 1'b1});
            end
            else begin
                last_id             = last_id + 1'b1;
                slot_busy[slot]     = 1'b1;
                slot_deadline[slot] = dl;
                slot_id[slot]       = last_id;
                slot_tag[slot]      = tag;
                words.push_back(timer_word_t'{KIND_ACCEPT, last_id, tag, dl, 1'b1});
            end
        end
        else begin
            now_ms = now_ms + 1'b1;
            held   = 1'b0;
            done   = 1'b0;
            fired  = 0;
            while (!done && fired < MAX_RESULTS) begin
                best = -1;
                for (int i = 0; i < SLOTS; i++) begin
                    if (slot_busy[i] && slot_deadline[i] <= now_ms) begin
                        if (best < 0 || slot_deadline[i] < slot_deadline[best] ||
                            (slot_deadline[i] == slot_deadline[best] &&
                             slot_id[i] < slot_id[best]))
                            best = i;
                    end
                end
                if (best < 0) begin
                    done = 1'b1;
                end
                else begin
                    if (held)
                        words.push_back(w);
                    w = '{KIND_FIRED, slot_id[best], slot_tag[best], slot_deadline[best], 1'b0};
                    held            = 1'b1;
                    slot_busy[best] = 1'b0;
                    fired++;
                end
            end
            // mark the final fired word
            if (held) begin
                w.last = 1'b1;
                words.push_back(w);
            end
        end
    endfunction

    task automatic send_word(input logic [CMD_W-1:0] cmd, input logic [DELAY_W-1:0] delay,
                             input logic [TAG_W-1:0] tag, input bit typed,
                             input timer_word_t want);
        int          gap;
        timer_word_t words [$];

        gap = (!calm && $urandom_range(0, 7) == 0) ? $urandom_range(1, 6) : 0;
        if (gap > 0) begin
            req_bus.valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        req_bus.valid    <= 1'b1;
        req_bus.cmd      <= cmd;
        req_bus.delay_ms <= delay;
        req_bus.tag      <= tag;
        @(posedge clk);
        while (!req_bus.ready)
            @(posedge clk);
        step_timers(cmd, delay, tag, words);
        if (typed)
            due_words.push_back(want);
        else
            foreach (words[k])
                due_words.push_back(words[k]);
    endtask

    // Response side: random stall bursts, one long hold on request, none when calm
    initial begin
        int stall_left;

        stall_left = 0;
        rsp_bus.ready <= 1'b0;
        forever begin
            @(posedge clk);
            if (hold_rsp) begin
                hold_rsp  <= 1'b0;
                stall_left = LONG_HOLD;
            end
            if (stall_left > 0) begin
                stall_left--;
                rsp_bus.ready <= 1'b0;
            end
            else if (!calm && $urandom_range(0, 9) == 0) begin
                stall_left = $urandom_range(0, 5);
                rsp_bus.ready <= 1'b0;
            end
            else begin
                rsp_bus.ready <= 1'b1;
            end
        end
    end

    always @(posedge clk) begin
        timer_word_t want;

        if (rst_n && rsp_bus.valid && rsp_bus.ready) begin
            if (due_words.size() == 0) begin
                report_mismatch($sformatf("unexpected word kind %0d id %0d tag %0h",
                                          rsp_bus.kind, rsp_bus.timer_id, rsp_bus.fired_tag));
            end
            else begin
                want = due_words.pop_front();
                if (rsp_bus.kind !== want.kind)
                    report_mismatch($sformatf("kind %0d, want %0d", rsp_bus.kind, want.kind));
                if (rsp_bus.timer_id !== want.id)
                    report_mismatch($sformatf("timer_id %0d, want %0d",
                                              rsp_bus.timer_id, want.id));
                if (rsp_bus.fired_tag !== want.tag)
                    report_mismatch($sformatf("fired_tag %0h, want %0h",
                                              rsp_bus.fired_tag, want.tag));
                if (rsp_bus.deadline !== want.deadline)
                    report_mismatch($sformatf("deadline %0h, want %0h",
                                              rsp_bus.deadline, want.deadline));
                if (rsp_bus.last !== want.last)
                    report_mismatch($sformatf("last %0b, want %0b", rsp_bus.last, want.last));
            end
        end
    end

    always @(posedge clk) begin
        cycle_count++;
        if (cycle_count >= CYCLE_LIMIT) begin
            $display("simulation failed");
            $finish;
        end
    end

    initial begin
        int                 add_pct [6] = '{55, 30, 85, 45, 70, 50};
        int                 pick;
        logic [CMD_W-1:0]   cmd;
        logic [DELAY_W-1:0] delay;

        for (int i = 0; i < SLOTS; i++)
            slot_busy[i] = 1'b0;
        req_bus.valid    <= 1'b0;
        req_bus.cmd      <= CMD_ADD;
        req_bus.delay_ms <= '0;
        req_bus.tag      <= '0;
        repeat (3) @(posedge clk);
        rst_n <= 1'b1;

        foreach (dir_rows[r])
            for (int k = 0; k < dir_rows[r].reps; k++)
                send_word(dir_rows[r].cmd, dir_rows[r].delay, dir_rows[r].tag + k[TAG_W-1:0],
                          dir_rows[r].typed, dir_rows[r].want);

        for (int i = 0; i < RANDOM_WORDS; i++) begin
            if (i == RANDOM_WORDS - CALM_WORDS)
                calm <= 1'b1;
            if (i == 50)
                hold_rsp <= 1'b1;
            // drain everything before going on
            if (i == 120) begin
                req_bus.valid <= 1'b0;
                while (due_words.size() != 0)
                    @(posedge clk);
                @(posedge clk);
            end
            if ($urandom_range(0, 99) < add_pct[(i / 40) % 6]) begin
                cmd  = CMD_ADD;
                pick = $urandom_range(0, 99);
                if (pick < 35)
                    delay = $urandom_range(0, 3);
                else if (pick < 85)
                    delay = $urandom_range(0, 24);
                else if (pick < 95)
                    delay = $urandom_range(25, 80);
                else if (permanent < MAX_PERMANENT) begin
                    // these never fire and hold a slot for the rest of the run
                    delay = $urandom | 32'h0100_0000;
                    permanent++;
                end
                else
                    delay = $urandom_range(0, 24);
            end
            else begin
                cmd   = CMD_TICK;
                delay = $urandom;
            end
            send_word(cmd, delay, TAG_W'($urandom_range(0, 16'hFFFF)), 1'b0, '0);
        end
        req_bus.valid <= 1'b0;

        while (due_words.size() != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);

        if (mismatches == 0)
            $display("simulation ok");
        else
            $display("simulation failed");
        $finish;
    end

endmodule
